>>> rtl/mmul4_pkg.sv
// shared types and constants for the 4x4 fixed-point matrix multiplier
`default_nettype none

package mmul4_pkg;

  localparam int DIM        = 4;
  localparam int IDX_BITS   = 2;
  localparam int CNT_BITS   = 4;
  localparam int VALUE_BITS = 32;
  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 16;

  typedef enum logic {
    SEL_LEFT  = 1'b0,
    SEL_RIGHT = 1'b1
  } mat_sel_e;

  typedef struct packed {
    logic                en;
    mat_sel_e            sel;
    logic [IDX_BITS-1:0] row;
    logic [IDX_BITS-1:0] col;
  } wr_t;

  typedef struct packed {
    logic                valid;
    logic [IDX_BITS-1:0] row;
    logic [IDX_BITS-1:0] col;
    logic                last;
  } tag_t;

endpackage

`default_nettype wire

>>> rtl/mmul4_if.sv
// valid/ready channel interfaces for element loads and product results
`default_nettype none

interface mmul4_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] element_value;
  logic        matrix_select;
  logic [1:0]  row_index;
  logic [1:0]  col_index;
  logic        last_element;

  modport source (
    output valid, element_value, matrix_select, row_index, col_index, last_element,
    input  ready
  );
  modport sink (
    input  valid, element_value, matrix_select, row_index, col_index, last_element,
    output ready
  );
endinterface

interface mmul4_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] product_value;
  logic [1:0]  out_row;
  logic [1:0]  out_col;
  logic        saturated;
  logic        last_result;

  modport source (
    output valid, product_value, out_row, out_col, saturated, last_result,
    input  ready
  );
  modport sink (
    input  valid, product_value, out_row, out_col, saturated, last_result,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/matrix4x4_multiply.sv
// top level: element loading, product sequencing, cell chain and saturating output
//
//   channel  dir  fields                                                     transaction
//   in_i     in   element_value matrix_select row_index col_index last_element  valid & ready
//   out_o    out  product_value out_row out_col saturated last_result         valid & ready
//
// a load marked last starts a run of 16 products
// products enter the chain of four cells one per cycle unless the output stalls, each cell
// adds one term in its two register stages; results leave one per cycle while not stalled
// loads are refused from the start of a run until its last result is taken
// a stalled output freezes the whole cell chain; reset clears control state only
`default_nettype none

module matrix4x4_multiply #(
  parameter int WordBits = mmul4_pkg::WORD_BITS,
  parameter int FracBits = mmul4_pkg::FRAC_BITS
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  mmul4_in_if.sink         in_i,
  mmul4_out_if.source      out_o
);

  localparam int SumW   = 2 * WordBits + 2;
  localparam int InExt  = (WordBits > mmul4_pkg::VALUE_BITS) ? WordBits
                                                            : mmul4_pkg::VALUE_BITS;
  localparam logic [mmul4_pkg::CNT_BITS-1:0] LastCnt =
    mmul4_pkg::CNT_BITS'(mmul4_pkg::DIM * mmul4_pkg::DIM - 1);

  logic                             busy_q, busy_d;
  logic                             issuing_q, issuing_d;
  logic [mmul4_pkg::CNT_BITS-1:0]   cnt_q, cnt_d;
  mmul4_pkg::tag_t                  issue_q, issue_d;
  logic                             en;
  logic                             in_hs, out_hs;

  mmul4_pkg::wr_t                   wr;
  logic signed [InExt-1:0]          in_ext;
  logic [WordBits-1:0]              wr_data;

  mmul4_pkg::tag_t                  tag_w [mmul4_pkg::DIM+1];
  logic signed [SumW-1:0]           sum_w [mmul4_pkg::DIM+1];

  logic [SumW-WordBits:0]           sum_top;
  logic                             clip;
  logic signed [WordBits-1:0]       sat_val;
  logic signed [InExt-1:0]          sat_ext;

  logic                             out_valid_q;
  logic [mmul4_pkg::VALUE_BITS-1:0] out_value_q;
  logic [mmul4_pkg::IDX_BITS-1:0]   out_row_q, out_col_q;
  logic                             out_sat_q, out_last_q;

  assign en     = !out_valid_q || out_o.ready;
  assign in_hs  = in_i.valid && !busy_q;
  assign out_hs = out_valid_q && out_o.ready;

  assign in_i.ready = !busy_q;

  // element write bus
  assign in_ext  = InExt'($signed(in_i.element_value));
  assign wr_data = in_ext[WordBits-1:0];
  always_comb begin
    wr.en  = in_hs;
    wr.sel = mmul4_pkg::mat_sel_e'(in_i.matrix_select);
    wr.row = in_i.row_index;
    wr.col = in_i.col_index;
  end

  // product sequencer
  always_comb begin
    busy_d    = busy_q;
    issuing_d = issuing_q;
    cnt_d     = cnt_q;
    issue_d   = issue_q;
    if (in_hs && in_i.last_element) begin
      busy_d    = 1'b1;
      issuing_d = 1'b1;
      cnt_d     = '0;
    end else begin
      if (en) begin
        issue_d.valid = issuing_q;
        issue_d.row   = cnt_q[mmul4_pkg::CNT_BITS-1 -: mmul4_pkg::IDX_BITS];
        issue_d.col   = cnt_q[mmul4_pkg::IDX_BITS-1:0];
        issue_d.last  = (cnt_q == LastCnt);
        if (issuing_q) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == LastCnt) begin
            issuing_d = 1'b0;
          end
        end
      end
      if (out_hs && out_last_q) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      issuing_q <= 1'b0;
      cnt_q     <= '0;
      issue_q   <= '0;
    end else begin
      busy_q    <= busy_d;
      issuing_q <= issuing_d;
      cnt_q     <= cnt_d;
      issue_q   <= issue_d;
    end
  end

  // cell chain
  assign tag_w[0] = issue_q;
  assign sum_w[0] = '0;

  for (genvar k = 0; k < mmul4_pkg::DIM; k++) begin : g_cell
    mmul4_cell #(
      .WordBits (WordBits),
      .FracBits (FracBits),
      .CellIdx  (k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .wr_i      (wr),
      .wr_data_i (wr_data),
      .tag_i     (tag_w[k]),
      .sum_i     (sum_w[k]),
      .tag_o     (tag_w[k+1]),
      .sum_o     (sum_w[k+1])
    );
  end

  // saturation to the word range
  assign sum_top = sum_w[mmul4_pkg::DIM][SumW-1:WordBits-1];
  assign clip    = !((&sum_top) || !(|sum_top));
  assign sat_val = clip ? $signed({sum_w[mmul4_pkg::DIM][SumW-1],
                                   {(WordBits-1){~sum_w[mmul4_pkg::DIM][SumW-1]}}})
                        : sum_w[mmul4_pkg::DIM][WordBits-1:0];
  assign sat_ext = InExt'(sat_val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= tag_w[mmul4_pkg::DIM].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_value_q <= sat_ext[mmul4_pkg::VALUE_BITS-1:0];
      out_row_q   <= tag_w[mmul4_pkg::DIM].row;
      out_col_q   <= tag_w[mmul4_pkg::DIM].col;
      out_sat_q   <= clip;
      out_last_q  <= tag_w[mmul4_pkg::DIM].last;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.product_value = out_value_q;
  assign out_o.out_row       = out_row_q;
  assign out_o.out_col       = out_col_q;
  assign out_o.saturated     = out_sat_q;
  assign out_o.last_result   = out_last_q;

  a_busy_when_issuing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    issuing_q |-> busy_q)
    else $error("products issued outside a run");

  a_issue_in_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_q.valid |-> busy_q)
    else $error("chain entry valid outside a run");

  a_no_load_with_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !in_i.ready)
    else $error("load accepted while a result is pending");

  a_idle_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_hs && out_last_q) |=> (!busy_q && !issuing_q))
    else $error("run not closed after last result transaction");

endmodule

`default_nettype wire

>>> rtl/mmul4_cell.sv
// one multiply-accumulate cell holding left column k and right row k
`default_nettype none

module mmul4_cell #(
  parameter int WordBits = mmul4_pkg::WORD_BITS,
  parameter int FracBits = mmul4_pkg::FRAC_BITS,
  parameter int CellIdx  = 0
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              en_i,
  input  mmul4_pkg::wr_t                   wr_i,
  input  wire  [WordBits-1:0]              wr_data_i,
  input  mmul4_pkg::tag_t                  tag_i,
  input  wire  signed [2*WordBits+1:0]     sum_i,
  output mmul4_pkg::tag_t                  tag_o,
  output logic signed [2*WordBits+1:0]     sum_o
);

  localparam int SumW = 2 * WordBits + 2;
  localparam logic [mmul4_pkg::IDX_BITS-1:0] MyIdx = mmul4_pkg::IDX_BITS'(CellIdx);

  logic [WordBits-1:0] left_q  [mmul4_pkg::DIM];
  logic [WordBits-1:0] right_q [mmul4_pkg::DIM];

  logic signed [2*WordBits-1:0] prod_d, prod_a_q, prod_shift;
  logic signed [SumW-1:0]       sum_a_q, sum_b_d, sum_b_q;
  mmul4_pkg::tag_t              tag_a_q, tag_b_q;

  // element stores
  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.sel == mmul4_pkg::SEL_LEFT && wr_i.col == MyIdx) begin
      left_q[wr_i.row] <= wr_data_i;
    end
    if (wr_i.en && wr_i.sel == mmul4_pkg::SEL_RIGHT && wr_i.row == MyIdx) begin
      right_q[wr_i.col] <= wr_data_i;
    end
  end

  assign prod_d     = $signed(left_q[tag_i.row]) * $signed(right_q[tag_i.col]);
  assign prod_shift = prod_a_q >>> FracBits;
  assign sum_b_d    = sum_a_q + SumW'(prod_shift);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
    end else if (en_i) begin
      tag_a_q <= tag_i;
      tag_b_q <= tag_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_a_q <= prod_d;
      sum_a_q  <= sum_i;
      sum_b_q  <= sum_b_d;
    end
  end

  assign tag_o = tag_b_q;
  assign sum_o = sum_b_q;

endmodule

`default_nettype wire

>>> tb/matrix4x4_multiply_tb.sv
// self-checking testbench for the 4x4 fixed-point matrix multiplier
`timescale 1ns / 1ps

module matrix4x4_multiply_tb;

  localparam int  CLK_HALF      = 5;
  localparam int  RESET_CYCLES  = 12;
  localparam int  RANDOM_LOADS  = 168;
  localparam int  DRAIN_CYCLES  = 40;
  localparam int  CYCLE_LIMIT   = 200000;
  localparam int  REPORT_MAX    = 10;
  localparam longint SUM_HI     = 64'sd2147483647;
  localparam longint SUM_LO     = -64'sd2147483648;

  typedef struct packed {
    logic [31:0]         value;
    mmul4_pkg::mat_sel_e sel;
    logic [1:0]          row;
    logic [1:0]          col;
    logic                last;
    logic                has_typed;
    logic [31:0]         typed_value;
    logic                typed_sat;
  } load_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  row;
    logic [1:0]  col;
    logic        sat;
    logic        last;
  } product_t;

  // typed columns give the expected element at row 0, column 0
  localparam load_t DIRECTED_LOADS [20] = '{
    '{32'h7fffffff, mmul4_pkg::SEL_LEFT,  2'd0, 2'd0, 1'b0, 1'b0, 32'h00000000, 1'b0},
    '{32'h7fffffff, mmul4_pkg::SEL_RIGHT, 2'd0, 2'd0, 1'b1, 1'b1, 32'h7fffffff, 1'b1},
    '{32'h80000000, mmul4_pkg::SEL_RIGHT, 2'd0, 2'd0, 1'b1, 1'b1, 32'h80000000, 1'b1},
    '{32'h80000000, mmul4_pkg::SEL_LEFT,  2'd0, 2'd0, 1'b1, 1'b1, 32'h7fffffff, 1'b1},
    '{32'h00010000, mmul4_pkg::SEL_LEFT,  2'd0, 2'd0, 1'b0, 1'b0, 32'h00000000, 1'b0},
    '{32'h00010000, mmul4_pkg::SEL_RIGHT, 2'd0, 2'd0, 1'b1, 1'b1, 32'h00010000, 1'b0},
    '{32'hffffffff, mmul4_pkg::SEL_RIGHT, 2'd0, 2'd0, 1'b1, 1'b1, 32'hffffffff, 1'b0},
    '{32'h00000001, mmul4_pkg::SEL_LEFT,  2'd0, 2'd0, 1'b1, 1'b1, 32'hffffffff, 1'b0},
    '{32'h00000000, mmul4_pkg::SEL_LEFT,  2'd0, 2'd0, 1'b1, 1'b1, 32'h00000000, 1'b0},
    '{32'h40000000, mmul4_pkg::SEL_LEFT,  2'd0, 2'd0, 1'b0, 1'b0, 32'h00000000, 1'b0},
    '{32'h40000000, mmul4_pkg::SEL_LEFT,  2'd0, 2'd1, 1'b0, 1'b0, 32'h00000000, 1'b0},
    '{32'h40000000, mmul4_pkg::SEL_LEFT,  2'd0, 2'd2, 1'b0, 1'b0, 32'h00000000, 1'b0},
    '{32'h40000000, mmul4_pkg::SEL_LEFT,  2'd0, 2'd3, 1'b0, 1'b0, 32'h00000000, 1'b0},
    '{32'h00008000, mmul4_pkg::SEL_RIGHT, 2'd0, 2'd0, 1'b0, 1'b0, 32'h00000000, 1'b0},
    '{32'h00008000, mmul4_pkg::SEL_RIGHT, 2'd1, 2'd0, 1'b0, 1'b0, 32'h00000000, 1'b0},
    '{32'h00008000, mmul4_pkg::SEL_RIGHT, 2'd2, 2'd0, 1'b0, 1'b0, 32'h00000000, 1'b0},
    '{32'h00008000, mmul4_pkg::SEL_RIGHT, 2'd3, 2'd0, 1'b1, 1'b1, 32'h7fffffff, 1'b1},
    '{32'hffff8000, mmul4_pkg::SEL_RIGHT, 2'd3, 2'd0, 1'b1, 1'b1, 32'h40000000, 1'b0},
    '{32'h7fffffff, mmul4_pkg::SEL_LEFT,  2'd3, 2'd3, 1'b1, 1'b1, 32'h40000000, 1'b0},
    '{32'h80000000, mmul4_pkg::SEL_RIGHT, 2'd3, 2'd3, 1'b1, 1'b0, 32'h00000000, 1'b0}
  };

  logic clk_i;
  logic rst_ni;

  mmul4_in_if  in_if ();
  mmul4_out_if out_if ();

  matrix4x4_multiply i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  logic signed [31:0] left_store  [16];
  logic signed [31:0] right_store [16];
  product_t           expected_products [$];
  int                 fail_count;
  int                 cycle_count;
  int                 idle_max;

  initial begin
    clk_i = 1'b0;
  end

  always #CLK_HALF clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic void predict_load(input load_t item);
    longint   acc;
    longint   term;
    product_t res;
    if (item.sel == mmul4_pkg::SEL_RIGHT) begin
      right_store[{item.row, item.col}] = item.value;
    end else begin
      left_store[{item.row, item.col}] = item.value;
    end
    if (!item.last) return;
    for (int i = 0; i < mmul4_pkg::DIM; i++) begin
      for (int j = 0; j < mmul4_pkg::DIM; j++) begin
        acc = 0;
        for (int k = 0; k < mmul4_pkg::DIM; k++) begin
          term = longint'(left_store[i * mmul4_pkg::DIM + k]) *
                 longint'(right_store[k * mmul4_pkg::DIM + j]);
          acc += term >>> mmul4_pkg::FRAC_BITS;
        end
        res.sat = 1'b0;
        if (acc > SUM_HI) begin
          acc     = SUM_HI;
          res.sat = 1'b1;
        end else if (acc < SUM_LO) begin
          acc     = SUM_LO;
          res.sat = 1'b1;
        end
        res.value = acc[31:0];
        if (item.has_typed && i == 0 && j == 0) begin
          res.value = item.typed_value;
          res.sat   = item.typed_sat;
        end
        res.row  = 2'(i);
        res.col  = 2'(j);
        res.last = (i == mmul4_pkg::DIM - 1) && (j == mmul4_pkg::DIM - 1);
        expected_products.push_back(res);
      end
    end
  endfunction

  function automatic logic [31:0] random_element_value();
    logic [31:0] pick;
    case ($urandom_range(0, 7))
      0: pick = $urandom();
      1: begin
        case ($urandom_range(0, 4))
          0: pick = 32'h7fffffff;
          1: pick = 32'h80000000;
          2: pick = 32'h00000000;
          3: pick = 32'hffffffff;
          default: pick = 32'h00010000;
        endcase
      end
      default: pick = 32'(int'($urandom_range(0, 32'h00200000)) - 32'sh00100000);
    endcase
    return pick;
  endfunction

  task automatic send_load(input load_t item);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.element_value <= item.value;
    in_if.matrix_select <= item.sel;
    in_if.row_index     <= item.row;
    in_if.col_index     <= item.col;
    in_if.last_element  <= item.last;
    do @(posedge clk_i); while (!in_if.ready);
    predict_load(item);
  endtask

  // result side: random stalls, checks against the oldest expectation
  initial begin
    int       gap;
    product_t got;
    product_t want;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      gap = $urandom_range(0, idle_max);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
      got = '{out_if.product_value, out_if.out_row, out_if.out_col,
              out_if.saturated, out_if.last_result};
      if (expected_products.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
          $display("unexpected transaction: value %h row %0d col %0d sat %0b last %0b",
                   got.value, got.row, got.col, got.sat, got.last);
        end
      end else begin
        want = expected_products.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) begin
            $display("mismatch: expected value %h row %0d col %0d sat %0b last %0b",
                     want.value, want.row, want.col, want.sat, want.last);
            $display("          actual   value %h row %0d col %0d sat %0b last %0b",
                     got.value, got.row, got.col, got.sat, got.last);
          end
        end
      end
    end
  end

  initial begin
    load_t item;
    fail_count          = 0;
    cycle_count         = 0;
    idle_max            = 3;
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.element_value = '0;
    in_if.matrix_select = mmul4_pkg::SEL_LEFT;
    in_if.row_index     = '0;
    in_if.col_index     = '0;
    in_if.last_element  = 1'b0;
    for (int n = 0; n < 16; n++) begin
      left_store[n]  = '0;
      right_store[n] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // fill both matrices before any product reads them
    for (int n = 0; n < 2 * mmul4_pkg::DIM * mmul4_pkg::DIM; n++) begin
      item           = '0;
      item.sel       = (n < mmul4_pkg::DIM * mmul4_pkg::DIM) ? mmul4_pkg::SEL_LEFT
                                                             : mmul4_pkg::SEL_RIGHT;
      item.row       = 2'(n / mmul4_pkg::DIM);
      item.col       = 2'(n);
      item.last      = (n == 2 * mmul4_pkg::DIM * mmul4_pkg::DIM - 1);
      send_load(item);
    end

    foreach (DIRECTED_LOADS[n]) send_load(DIRECTED_LOADS[n]);

    for (int n = 0; n < RANDOM_LOADS; n++) begin
      item       = '0;
      item.value = random_element_value();
      item.sel   = mmul4_pkg::mat_sel_e'($urandom_range(0, 1));
      item.row   = 2'($urandom_range(0, 3));
      item.col   = 2'($urandom_range(0, 3));
      item.last  = ($urandom_range(0, 7) == 0) || (n == RANDOM_LOADS - 1);
      send_load(item);
    end
    in_if.valid <= 1'b0;

    while (expected_products.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/mmul4_pkg.sv
rtl/mmul4_if.sv
rtl/mmul4_cell.sv
rtl/matrix4x4_multiply.sv
tb/matrix4x4_multiply_tb.sv
